FILE: hdl/ffac_pkg.sv
`default_nettype none
package ffac_pkg;

  localparam int ADDR_BITS   = 40;
  localparam int LEN_BITS    = 41;
  localparam int GRAN_BITS   = 21;
  localparam int SIZE_BITS   = 42;
  localparam int NEXT_BITS   = 48;
  localparam int TABLE_DEPTH = 32;
  localparam int UNIT_BITS   = 9;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_FREEZE = 2'd2,
    ACT_BAD    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD      = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_NOT_FND  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  localparam logic KIND_ANSWER = 1'b0;
  localparam logic KIND_MOVE   = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_REM, S_CHECK, S_SCAN_RD, S_SCAN_CHK, S_CMP_RD, S_CMP_CHK,
    S_CMP_EMIT, S_SHUP_RD, S_SHUP_WR, S_INS, S_FREE_RD, S_FREE_CHK,
    S_SHDN_RD, S_SHDN_WR, S_ANSWER
  } state_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [LEN_BITS-1:0]  request_bytes;
    logic [GRAN_BITS-1:0] granule_bytes;
    logic [ADDR_BITS-1:0] free_address;
  } in_t;

  typedef struct packed {
    logic                 kind;
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] block_address;
    logic [ADDR_BITS-1:0] move_source;
    logic [ADDR_BITS-1:0] move_dest;
    logic [LEN_BITS-1:0]  move_length;
    logic [LEN_BITS-1:0]  bytes_in_use;
    logic [LEN_BITS-1:0]  peak_in_use;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  len;
    logic                 frozen;
  } entry_t;

endpackage
`default_nettype wire

FILE: hdl/ffac_table.sv
`default_nettype none
module ffac_table #(
  parameter int DEPTH = ffac_pkg::TABLE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire ffac_pkg::entry_t         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output ffac_pkg::entry_t              rdata
);

  ffac_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/ffac_rem.sv
`default_nettype none
module ffac_rem (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ffac_pkg::LEN_BITS-1:0]  dividend,
  input  wire logic [ffac_pkg::GRAN_BITS-1:0] divisor,
  output logic                                done,
  output logic [ffac_pkg::GRAN_BITS-1:0]      remainder
);

  localparam int CW = $clog2(ffac_pkg::LEN_BITS + 1);

  logic [ffac_pkg::LEN_BITS-1:0]  dvd;
  logic [ffac_pkg::GRAN_BITS-1:0] dsr;
  logic [CW-1:0]                  cnt;
  logic                           run;
  logic [ffac_pkg::GRAN_BITS:0]   trial;
  logic [ffac_pkg::GRAN_BITS:0]   trial_sub;

  // one quotient bit per cycle, restoring
  assign trial     = {remainder, dvd[ffac_pkg::LEN_BITS-1]};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(ffac_pkg::LEN_BITS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (run) begin
      dvd <= {dvd[ffac_pkg::LEN_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        remainder <= trial_sub[ffac_pkg::GRAN_BITS-1:0];
      end else begin
        remainder <= trial[ffac_pkg::GRAN_BITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/first_fit_allocator_compacting_core.sv
`default_nettype none
// First-fit pool allocator with compaction. One request is taken at a time;
// in_stall stays high until its final answer has been loaded. An allocation
// first rounds the size up to the granule in a bit-serial remainder unit,
// then walks the block table through a memory with one read and one write
// port, with a read state and a check state per entry: the first-fit scan,
// then a compaction pass if needed (read, check and emit states per shifted
// block, the emit state sending its move request and waiting out any output
// stall) or else a shift of the entries above the insert point. A free walks
// to the matching entry and shifts the entries above it down, with a read
// and a write state per entry. A freeze walks and compacts the live blocks.
module first_fit_allocator_compacting_core #(
  parameter int TABLE_DEPTH = ffac_pkg::TABLE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ffac_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ffac_pkg::out_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [ffac_pkg::LEN_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = ffac_pkg::NEXT_BITS;
  localparam int AB = ffac_pkg::ADDR_BITS;
  localparam int LB = ffac_pkg::LEN_BITS;
  localparam int GB = ffac_pkg::GRAN_BITS;
  localparam int SB = ffac_pkg::SIZE_BITS;

  ffac_pkg::state_t  state, state_next;
  logic [1:0]        op, op_next;
  logic [LB-1:0]     req, req_next;
  logic [GB-1:0]     gran, gran_next;
  logic [AB-1:0]     faddr, faddr_next;
  logic [SB-1:0]     size, size_next;
  logic [NW-1:0]     nxt, nxt_next;
  logic [IW-1:0]     idx, idx_next;
  logic [IW-1:0]     first, first_next;
  logic              live_seen, live_seen_next;
  logic [IW-1:0]     pos, pos_next;
  logic [IW-1:0]     count, count_next;
  logic [AB-1:0]     live_base, live_base_next;
  logic [LB-1:0]     in_use, in_use_next;
  logic [LB-1:0]     peak, peak_next;
  logic [AB-1:0]     pool_base, pool_base_next;
  logic [LB-1:0]     pool_size, pool_size_next;
  logic [2:0]        ans_status, ans_status_next;
  logic [AB-1:0]     ans_addr, ans_addr_next;
  logic [AB-1:0]     cur_start, cur_start_next;
  logic [LB-1:0]     cur_len, cur_len_next;

  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  ffac_pkg::entry_t  tbl_wdata;
  logic [AW-1:0]     tbl_raddr;
  ffac_pkg::entry_t  tbl_rdata;

  logic              rem_start;
  logic              rem_done;
  logic [GB-1:0]     rem_val;

  logic              out_load;
  ffac_pkg::out_t    out_next;
  logic              out_free;
  logic              accept;
  logic              is_freeze;
  logic [NW-1:0]     end_addr;
  logic [NW-1:0]     nxt_plus_size;
  logic [LB-1:0]     avail;
  logic [LB-1:0]     in_use_add;
  logic [IW-1:0]     idx_m1;
  logic [IW-1:0]     idx_p1;

  ffac_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  ffac_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (in_data.request_bytes),
    .divisor   (in_data.granule_bytes),
    .done      (rem_done),
    .remainder (rem_val)
  );

  assign in_stall      = (state != ffac_pkg::S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign out_free      = !out_valid || !out_stall;
  assign is_freeze     = (op == ffac_pkg::ACT_FREEZE);
  assign end_addr      = NW'(pool_base) + NW'(pool_size);
  assign nxt_plus_size = nxt + NW'(size);
  assign avail         = (in_use > pool_size) ? '0 : pool_size - in_use;
  assign in_use_add    = in_use + size[LB-1:0];
  assign idx_m1        = idx - 1'b1;
  assign idx_p1        = idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffac_pkg::S_IDLE;
      count     <= '0;
      live_base <= '0;
      in_use    <= '0;
      peak      <= '0;
      pool_base <= '0;
      pool_size <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      live_base <= live_base_next;
      in_use    <= in_use_next;
      peak      <= peak_next;
      pool_base <= pool_base_next;
      pool_size <= pool_size_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    req        <= req_next;
    gran       <= gran_next;
    faddr      <= faddr_next;
    size       <= size_next;
    nxt        <= nxt_next;
    idx        <= idx_next;
    first      <= first_next;
    live_seen  <= live_seen_next;
    pos        <= pos_next;
    ans_status <= ans_status_next;
    ans_addr   <= ans_addr_next;
    cur_start  <= cur_start_next;
    cur_len    <= cur_len_next;
    if (out_load) begin
      out_data <= out_next;
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    req_next        = req;
    gran_next       = gran;
    faddr_next      = faddr;
    size_next       = size;
    nxt_next        = nxt;
    idx_next        = idx;
    first_next      = first;
    live_seen_next  = live_seen;
    pos_next        = pos;
    count_next      = count;
    live_base_next  = live_base;
    in_use_next     = in_use;
    peak_next       = peak;
    pool_base_next  = pool_base;
    pool_size_next  = pool_size;
    ans_status_next = ans_status;
    ans_addr_next   = ans_addr;
    cur_start_next  = cur_start;
    cur_len_next    = cur_len;
    tbl_we          = 1'b0;
    tbl_waddr       = idx[AW-1:0];
    tbl_wdata       = tbl_rdata;
    tbl_raddr       = idx[AW-1:0];
    rem_start       = 1'b0;
    out_load        = 1'b0;
    out_next        = '0;

    case (state)
      ffac_pkg::S_IDLE: begin
        if (accept) begin
          op_next         = in_data.action;
          req_next        = in_data.request_bytes;
          gran_next       = in_data.granule_bytes;
          faddr_next      = in_data.free_address;
          idx_next        = '0;
          live_seen_next  = 1'b0;
          ans_addr_next   = '0;
          ans_status_next = ffac_pkg::ST_OK;
          case (in_data.action)
            ffac_pkg::ACT_ALLOC: begin
              if (in_data.request_bytes == '0 || in_data.granule_bytes == '0 ||
                  in_data.granule_bytes[ffac_pkg::UNIT_BITS-1:0] != '0) begin
                ans_status_next = ffac_pkg::ST_BAD;
                state_next      = ffac_pkg::S_ANSWER;
              end else begin
                rem_start  = 1'b1;
                state_next = ffac_pkg::S_REM;
              end
            end
            ffac_pkg::ACT_FREE:   state_next = ffac_pkg::S_FREE_RD;
            ffac_pkg::ACT_FREEZE: state_next = ffac_pkg::S_SCAN_RD;
            default: begin
              ans_status_next = ffac_pkg::ST_BAD;
              state_next      = ffac_pkg::S_ANSWER;
            end
          endcase
        end
      end

      ffac_pkg::S_REM: begin
        if (rem_done) begin
          // round up: add the shortfall to the next granule boundary
          if (rem_val == '0) begin
            size_next = SB'(req);
          end else begin
            size_next = SB'(req) + SB'(gran - rem_val);
          end
          state_next = ffac_pkg::S_CHECK;
        end
      end

      ffac_pkg::S_CHECK: begin
        nxt_next = NW'(live_base);
        if (size > SB'(avail)) begin
          ans_status_next = ffac_pkg::ST_NO_SPACE;
          state_next      = ffac_pkg::S_ANSWER;
        end else if (count >= IW'(TABLE_DEPTH)) begin
          ans_status_next = ffac_pkg::ST_FULL;
          state_next      = ffac_pkg::S_ANSWER;
        end else begin
          state_next = ffac_pkg::S_SCAN_RD;
        end
      end

      ffac_pkg::S_SCAN_RD: begin
        if (idx >= count) begin
          if (!live_seen) begin
            first_next = idx;
          end
          if (is_freeze) begin
            state_next = ffac_pkg::S_ANSWER;
          end else if (nxt_plus_size > end_addr) begin
            idx_next   = live_seen ? first : idx;
            nxt_next   = NW'(live_base);
            state_next = ffac_pkg::S_CMP_RD;
          end else begin
            pos_next   = count;
            idx_next   = count;
            state_next = ffac_pkg::S_SHUP_RD;
          end
        end else begin
          state_next = ffac_pkg::S_SCAN_CHK;
        end
      end

      ffac_pkg::S_SCAN_CHK: begin
        if (!live_seen && tbl_rdata.frozen) begin
          idx_next   = idx_p1;
          state_next = ffac_pkg::S_SCAN_RD;
        end else begin
          if (!live_seen) begin
            first_next     = idx;
            live_seen_next = 1'b1;
          end
          if (is_freeze) begin
            nxt_next   = NW'(live_base);
            state_next = ffac_pkg::S_CMP_RD;
          end else if (nxt_plus_size <= NW'(tbl_rdata.start)) begin
            pos_next   = idx;
            idx_next   = count;
            state_next = ffac_pkg::S_SHUP_RD;
          end else begin
            nxt_next   = NW'(tbl_rdata.start) + NW'(tbl_rdata.len);
            idx_next   = idx_p1;
            state_next = ffac_pkg::S_SCAN_RD;
          end
        end
      end

      ffac_pkg::S_CMP_RD: begin
        if (idx >= count) begin
          if (is_freeze) begin
            live_base_next = nxt[AB-1:0];
            state_next     = ffac_pkg::S_ANSWER;
          end else if (nxt_plus_size > end_addr) begin
            ans_status_next = ffac_pkg::ST_NO_SPACE;
            state_next      = ffac_pkg::S_ANSWER;
          end else begin
            pos_next   = count;
            idx_next   = count;
            state_next = ffac_pkg::S_SHUP_RD;
          end
        end else begin
          state_next = ffac_pkg::S_CMP_CHK;
        end
      end

      ffac_pkg::S_CMP_CHK: begin
        cur_start_next = tbl_rdata.start;
        cur_len_next   = tbl_rdata.len;
        if (nxt < NW'(tbl_rdata.start)) begin
          state_next = ffac_pkg::S_CMP_EMIT;
        end else begin
          tbl_we           = is_freeze;
          tbl_wdata        = tbl_rdata;
          tbl_wdata.frozen = 1'b1;
          nxt_next         = nxt + NW'(tbl_rdata.len);
          idx_next         = idx_p1;
          state_next       = ffac_pkg::S_CMP_RD;
        end
      end

      ffac_pkg::S_CMP_EMIT: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.kind        = ffac_pkg::KIND_MOVE;
          out_next.status      = ffac_pkg::ST_OK;
          out_next.move_source = cur_start;
          out_next.move_dest   = nxt[AB-1:0];
          out_next.move_length = cur_len;
          out_next.bytes_in_use = in_use;
          out_next.peak_in_use = peak;
          out_next.last        = 1'b0;
          tbl_we               = 1'b1;
          tbl_wdata.start      = nxt[AB-1:0];
          tbl_wdata.len        = cur_len;
          tbl_wdata.frozen     = is_freeze;
          nxt_next             = nxt + NW'(cur_len);
          idx_next             = idx_p1;
          state_next           = ffac_pkg::S_CMP_RD;
        end
      end

      // open a slot at pos by moving entries up from the top
      ffac_pkg::S_SHUP_RD: begin
        tbl_raddr = idx_m1[AW-1:0];
        if (idx == pos) begin
          state_next = ffac_pkg::S_INS;
        end else begin
          state_next = ffac_pkg::S_SHUP_WR;
        end
      end

      ffac_pkg::S_SHUP_WR: begin
        tbl_we     = 1'b1;
        tbl_wdata  = tbl_rdata;
        idx_next   = idx_m1;
        state_next = ffac_pkg::S_SHUP_RD;
      end

      ffac_pkg::S_INS: begin
        tbl_we           = 1'b1;
        tbl_waddr        = pos[AW-1:0];
        tbl_wdata.start  = nxt[AB-1:0];
        tbl_wdata.len    = size[LB-1:0];
        tbl_wdata.frozen = 1'b0;
        count_next       = count + 1'b1;
        in_use_next      = in_use_add;
        if (in_use_add > peak) begin
          peak_next = in_use_add;
        end
        ans_addr_next    = nxt[AB-1:0];
        ans_status_next  = ffac_pkg::ST_OK;
        state_next       = ffac_pkg::S_ANSWER;
      end

      ffac_pkg::S_FREE_RD: begin
        if (idx >= count) begin
          ans_status_next = ffac_pkg::ST_NOT_FND;
          state_next      = ffac_pkg::S_ANSWER;
        end else begin
          state_next = ffac_pkg::S_FREE_CHK;
        end
      end

      ffac_pkg::S_FREE_CHK: begin
        if (tbl_rdata.start == faddr) begin
          in_use_next = in_use - tbl_rdata.len;
          state_next  = ffac_pkg::S_SHDN_RD;
        end else begin
          idx_next   = idx_p1;
          state_next = ffac_pkg::S_FREE_RD;
        end
      end

      // close the gap by moving the entries above down one place
      ffac_pkg::S_SHDN_RD: begin
        tbl_raddr = idx_p1[AW-1:0];
        if (idx_p1 >= count) begin
          count_next = count - 1'b1;
          state_next = ffac_pkg::S_ANSWER;
        end else begin
          state_next = ffac_pkg::S_SHDN_WR;
        end
      end

      ffac_pkg::S_SHDN_WR: begin
        tbl_we     = 1'b1;
        tbl_wdata  = tbl_rdata;
        idx_next   = idx_p1;
        state_next = ffac_pkg::S_SHDN_RD;
      end

      ffac_pkg::S_ANSWER: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_next.kind          = ffac_pkg::KIND_ANSWER;
          out_next.status        = ans_status;
          out_next.block_address = ans_addr;
          out_next.bytes_in_use  = in_use;
          out_next.peak_in_use   = peak;
          out_next.last          = 1'b1;
          state_next             = ffac_pkg::S_IDLE;
        end
      end

      default: state_next = ffac_pkg::S_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_index)
        ffac_pkg::CFG_POOL_BASE: begin
          pool_base_next = cfg_data[AB-1:0];
          if (count == '0) begin
            live_base_next = cfg_data[AB-1:0];
          end
        end
        ffac_pkg::CFG_POOL_SIZE: pool_size_next = cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ffac_checker.sv
`default_nettype none
module ffac_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire ffac_pkg::out_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  a_last_vs_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.last != out_data.kind)
    else $error("last flag disagrees with result kind");

  // compaction only slides blocks downward
  a_move_down: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind |-> out_data.move_dest < out_data.move_source)
    else $error("move does not go down");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.peak_in_use >= out_data.bytes_in_use)
    else $error("peak below bytes in use");

endmodule

bind first_fit_allocator_compacting_core ffac_checker u_ffac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: tb/sv/first_fit_allocator_compacting_core_test.sv
`default_nettype none
module first_fit_allocator_compacting_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = ffac_pkg::TABLE_DEPTH;
  localparam int ADDR_BITS = ffac_pkg::ADDR_BITS;
  localparam int LEN_BITS = ffac_pkg::LEN_BITS;
  localparam int GRAN_BITS = ffac_pkg::GRAN_BITS;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ffac_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ffac_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [LEN_BITS-1:0] cfg_data = '0;

  first_fit_allocator_compacting_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // allocator shadow state
  logic [ADDR_BITS-1:0] pool_base_q;
  logic [LEN_BITS-1:0] pool_size_q;
  logic [ADDR_BITS-1:0] blk_start [DEPTH];
  logic [LEN_BITS-1:0] blk_len [DEPTH];
  logic blk_frozen [DEPTH];
  int blk_count;
  logic [ADDR_BITS-1:0] live_base_q;
  logic [LEN_BITS-1:0] in_use_q;
  logic [LEN_BITS-1:0] peak_q;

  ffac_pkg::out_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stall_free = 1'b0;

  function automatic void queue_result(ffac_pkg::out_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic ffac_pkg::out_t make_result(logic kind, ffac_pkg::status_t st,
                                                 logic [ADDR_BITS-1:0] addr,
                                                 logic [ADDR_BITS-1:0] src,
                                                 logic [ADDR_BITS-1:0] dst,
                                                 logic [LEN_BITS-1:0] len, logic lst);
    ffac_pkg::out_t r;
    r.kind = kind;
    r.status = st;
    r.block_address = addr;
    r.move_source = src;
    r.move_dest = dst;
    r.move_length = len;
    r.bytes_in_use = in_use_q;
    r.peak_in_use = peak_q;
    r.last = lst;
    return r;
  endfunction

  function automatic int first_live_index();
    int i;
    i = 0;
    while (i < blk_count && blk_frozen[i]) i++;
    return i;
  endfunction

  // slide live blocks down onto the live base, queue one move per shifted block
  function automatic logic [63:0] compact_live();
    logic [63:0] nxt;
    nxt = 64'(live_base_q);
    for (int i = first_live_index(); i < blk_count; i++) begin
      if (nxt < 64'(blk_start[i])) begin
        queue_result(make_result(ffac_pkg::KIND_MOVE, ffac_pkg::ST_OK, '0, blk_start[i],
                                 nxt[ADDR_BITS-1:0], blk_len[i], 1'b0));
        blk_start[i] = nxt[ADDR_BITS-1:0];
      end
      nxt += 64'(blk_len[i]);
    end
    return nxt;
  endfunction

  function automatic void insert_block(int pos, logic [63:0] addr, logic [63:0] len);
    for (int j = blk_count; j > pos; j--) begin
      blk_start[j] = blk_start[j-1];
      blk_len[j] = blk_len[j-1];
      blk_frozen[j] = blk_frozen[j-1];
    end
    blk_start[pos] = addr[ADDR_BITS-1:0];
    blk_len[pos] = len[LEN_BITS-1:0];
    blk_frozen[pos] = 1'b0;
    blk_count++;
    in_use_q = in_use_q + len[LEN_BITS-1:0];
    if (in_use_q > peak_q) peak_q = in_use_q;
  endfunction

  function automatic void answer(ffac_pkg::status_t st, logic [ADDR_BITS-1:0] addr);
    queue_result(make_result(ffac_pkg::KIND_ANSWER, st, addr, '0, '0, '0, 1'b1));
  endfunction

  function automatic void predict_request(ffac_pkg::in_t req);
    logic [63:0] pool_end, size, avail, nxt, gran, rb;
    int f;
    pool_end = 64'(pool_base_q) + 64'(pool_size_q);
    gran = 64'(req.granule_bytes);
    rb = 64'(req.request_bytes);
    case (ffac_pkg::action_t'(req.action))
      ffac_pkg::ACT_ALLOC: begin
        if (rb == 0 || gran == 0 || gran % 512 != 0) begin
          answer(ffac_pkg::ST_BAD, '0);
          return;
        end
        size = (rb + gran - 1) / gran * gran;
        avail = (in_use_q > pool_size_q) ? '0 : 64'(pool_size_q - in_use_q);
        if (size > avail) begin
          answer(ffac_pkg::ST_NO_SPACE, '0);
          return;
        end
        if (blk_count >= DEPTH) begin
          answer(ffac_pkg::ST_FULL, '0);
          return;
        end
        nxt = 64'(live_base_q);
        for (int i = first_live_index(); i < blk_count; i++) begin
          if (nxt + size <= 64'(blk_start[i])) begin
            insert_block(i, nxt, size);
            answer(ffac_pkg::ST_OK, nxt[ADDR_BITS-1:0]);
            return;
          end
          nxt = 64'(blk_start[i]) + 64'(blk_len[i]);
        end
        if (nxt + size > pool_end) begin
          nxt = compact_live();
          if (nxt + size > pool_end) begin
            answer(ffac_pkg::ST_NO_SPACE, '0);
            return;
          end
        end
        insert_block(blk_count, nxt, size);
        answer(ffac_pkg::ST_OK, nxt[ADDR_BITS-1:0]);
      end
      ffac_pkg::ACT_FREE: begin
        for (int i = 0; i < blk_count; i++) begin
          if (blk_start[i] == req.free_address) begin
            in_use_q = in_use_q - blk_len[i];
            for (int j = i; j + 1 < blk_count; j++) begin
              blk_start[j] = blk_start[j+1];
              blk_len[j] = blk_len[j+1];
              blk_frozen[j] = blk_frozen[j+1];
            end
            blk_count--;
            answer(ffac_pkg::ST_OK, '0);
            return;
          end
        end
        answer(ffac_pkg::ST_NOT_FND, '0);
      end
      ffac_pkg::ACT_FREEZE: begin
        f = first_live_index();
        if (f < blk_count) begin
          nxt = compact_live();
          live_base_q = nxt[ADDR_BITS-1:0];
          for (int i = f; i < blk_count; i++) blk_frozen[i] = 1'b1;
        end
        answer(ffac_pkg::ST_OK, '0);
      end
      default: begin
        answer(ffac_pkg::ST_BAD, '0);
      end
    endcase
  endfunction

  // the block is still busy in the cycle after it takes a request, so
  // the shortest gap here costs nothing
  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) @(posedge clk);
    else if (r < 93) repeat ($urandom_range(2, 4)) @(posedge clk);
    else repeat ($urandom_range(10, 60)) @(posedge clk);
  endtask

  task automatic send_request(ffac_pkg::in_t req);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
    in_valid <= 1'b0;
    idle_gap();
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic idx, logic [LEN_BITS-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffac_pkg::CFG_POOL_BASE) begin
      pool_base_q = val[ADDR_BITS-1:0];
      if (blk_count == 0) live_base_q = pool_base_q;
    end else begin
      pool_size_q = val;
    end
  endtask

  function automatic ffac_pkg::in_t alloc_req(logic [LEN_BITS-1:0] bytes,
                                              logic [GRAN_BITS-1:0] gran);
    ffac_pkg::in_t r;
    r = '0;
    r.action = ffac_pkg::ACT_ALLOC;
    r.request_bytes = bytes;
    r.granule_bytes = gran;
    r.free_address = ADDR_BITS'({$urandom, $urandom});
    return r;
  endfunction

  function automatic ffac_pkg::in_t op_req(ffac_pkg::action_t act,
                                           logic [ADDR_BITS-1:0] addr);
    ffac_pkg::in_t r;
    r.action = act;
    r.request_bytes = LEN_BITS'({$urandom, $urandom});
    r.granule_bytes = GRAN_BITS'($urandom);
    r.free_address = addr;
    return r;
  endfunction

  function automatic logic [GRAN_BITS-1:0] rand_granule();
    case ($urandom_range(0, 3))
      0: return GRAN_BITS'(512);
      1: return GRAN_BITS'(1024 * 1024);
      default: return GRAN_BITS'(512 * $urandom_range(1, 8));
    endcase
  endfunction

  // free every tracked block so the table ends empty
  task automatic free_all();
    while (blk_count > 0)
      send_request(op_req(ffac_pkg::ACT_FREE, blk_start[$urandom_range(0, blk_count - 1)]));
  endtask

  task automatic test_directed();
    write_reg(ffac_pkg::CFG_POOL_SIZE, LEN_BITS'(64'h8000));
    write_reg(ffac_pkg::CFG_POOL_BASE, LEN_BITS'(64'h1000));
    send_request(alloc_req('0, GRAN_BITS'(512)));
    send_request(alloc_req(LEN_BITS'(100), '0));
    send_request(alloc_req(LEN_BITS'(100), GRAN_BITS'(700)));
    send_request(op_req(ffac_pkg::ACT_BAD, '0));
    send_request(op_req(ffac_pkg::ACT_FREEZE, '0));
    send_request(alloc_req(LEN_BITS'(1), GRAN_BITS'(512)));
    send_request(alloc_req(LEN_BITS'(1000), GRAN_BITS'(1024)));
    send_request(alloc_req(LEN_BITS'(600), GRAN_BITS'(512)));
    send_request(alloc_req('1, GRAN_BITS'(512)));
    send_request(alloc_req(LEN_BITS'(64'h100_0000_0000), GRAN_BITS'(1024 * 1024)));
    send_request(op_req(ffac_pkg::ACT_FREE, ADDR_BITS'(64'h1200)));
    send_request(op_req(ffac_pkg::ACT_FREE, '1));
    send_request(alloc_req(LEN_BITS'(64'h5000), GRAN_BITS'(512)));
    send_request(alloc_req(LEN_BITS'(64'h1C00), GRAN_BITS'(512)));
    send_request(op_req(ffac_pkg::ACT_FREEZE, '0));
    send_request(alloc_req(LEN_BITS'(512), GRAN_BITS'(512)));
    send_request(op_req(ffac_pkg::ACT_FREE, ADDR_BITS'(64'h1000)));
    free_all();
  endtask

  task automatic test_full_table();
    write_reg(ffac_pkg::CFG_POOL_SIZE, LEN_BITS'(64'h10000));
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(alloc_req(LEN_BITS'(512), GRAN_BITS'(512)));
    free_all();
  endtask

  // hold off until all answers are back before the next request
  task automatic test_pause_drain();
    send_request(alloc_req(LEN_BITS'(2048), GRAN_BITS'(512)));
    wait_drained();
    send_request(alloc_req(LEN_BITS'(512), GRAN_BITS'(512)));
    wait_drained();
    free_all();
  endtask

  task automatic random_phase(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_request(alloc_req(LEN_BITS'($urandom_range(1, 6000)), rand_granule()));
      end else if (r < 80 && blk_count > 0) begin
        send_request(op_req(ffac_pkg::ACT_FREE, blk_start[$urandom_range(0, blk_count - 1)]));
      end else if (r < 86) begin
        send_request(op_req(ffac_pkg::ACT_FREEZE, '0));
      end else if (r < 92) begin
        send_request(alloc_req(LEN_BITS'({$urandom, $urandom}), GRAN_BITS'($urandom)));
      end else if (r < 96) begin
        send_request(op_req(ffac_pkg::ACT_FREE, ADDR_BITS'({$urandom, $urandom})));
      end else begin
        send_request(op_req(ffac_pkg::action_t'($urandom_range(0, 3)),
                            ADDR_BITS'({$urandom, $urandom})));
      end
    end
    free_all();
  endtask

  task automatic test_random();
    write_reg(ffac_pkg::CFG_POOL_BASE, LEN_BITS'(64'h2_0000));
    write_reg(ffac_pkg::CFG_POOL_SIZE, LEN_BITS'(64'h6000));
    random_phase(120);
    write_reg(ffac_pkg::CFG_POOL_BASE, '1);
    write_reg(ffac_pkg::CFG_POOL_SIZE, LEN_BITS'(64'h100_0000_0000));
    random_phase(80);
    write_reg(ffac_pkg::CFG_POOL_BASE, '0);
    write_reg(ffac_pkg::CFG_POOL_SIZE, LEN_BITS'(64'h3000));
    random_phase(100);
    write_reg(ffac_pkg::CFG_POOL_SIZE, '0);
    random_phase(20);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        errors++;
      end else begin
        ffac_pkg::out_t e;
        e = pending_results.pop_front();
        if (out_data !== e) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data);
          errors++;
        end
      end
    end
  end

  // output stall pattern: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 999);
    if (rst || stall_free) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (r < 5) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(10, 60);
    end else begin
      out_stall <= (r < 300);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    pool_base_q = '0;
    pool_size_q = '0;
    blk_count = 0;
    live_base_q = '0;
    in_use_q = '0;
    peak_q = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_pause_drain();
    wait_drained();
    test_random();
    stall_free = 1'b1;
    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
hdl/ffac_pkg.sv
hdl/ffac_table.sv
hdl/ffac_rem.sv
hdl/first_fit_allocator_compacting_core.sv
hdl/ffac_checker.sv
tb/sv/first_fit_allocator_compacting_core_test.sv
